// ----- design/jes_pkg.sv -----
// Shared types, constants and helpers of the 3x3 symmetric Jacobi eigen unit.
`default_nettype none
package jes_pkg;

    typedef logic signed [34:0] ent_t;
    typedef logic signed [31:0] q30_t;

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_PIVOT = 13'b0000000000010,
        S_PREP  = 13'b0000000000100,
        S_NORM  = 13'b0000000001000,
        S_SQA   = 13'b0000000010000,
        S_SQB   = 13'b0000000100000,
        S_SQC   = 13'b0000001000000,
        S_ROOT  = 13'b0000010000000,
        S_DIV   = 13'b0000100000000,
        S_TSQ   = 13'b0001000000000,
        S_TSQB  = 13'b0010000000000,
        S_MUL   = 13'b0100000000000,
        S_OUT   = 13'b1000000000000
    } state_t;

    localparam logic [0:0] CFG_MAX_ROT = 1'b0;
    localparam logic [0:0] CFG_THRESH  = 1'b1;

    localparam logic [4:0]  MAX_ROT_RESET = 5'd10;
    localparam logic [30:0] THRESH_RESET  = 31'd1;

    localparam logic [1:0] PV_01 = 2'd0;
    localparam logic [1:0] PV_02 = 2'd1;
    localparam logic [1:0] PV_12 = 2'd2;

    localparam logic [1:0] PAIR_LAST = 2'd2;
    localparam logic [4:0] OP_S      = 5'd0;
    localparam logic [4:0] OP_DIAG   = 5'd1;
    localparam logic [4:0] OP_LAST   = 5'd17;

    localparam logic [1:0] J_KPC = 2'd0;
    localparam logic [1:0] J_KQS = 2'd1;
    localparam logic [1:0] J_KQC = 2'd2;
    localparam logic [1:0] J_KPS = 2'd3;

    localparam logic [4:0] ROOT_STEPS = 5'd31;
    localparam logic [4:0] DIV_STEPS  = 5'd30;

    localparam q30_t        Q30_ONE  = 32'sd1073741824;
    localparam logic [63:0] ONE_60   = 64'h1000_0000_0000_0000;
    localparam logic [64:0] HALF_Q30 = 65'h0_2000_0000;

    localparam logic signed [36:0] ENT_LIM = 37'sd8589934591;
    localparam logic signed [36:0] I32_MAX = 37'sd2147483647;
    localparam logic signed [36:0] I32_MIN = -37'sd2147483648;

    function automatic logic [35:0] mag36(input logic signed [35:0] x);
        mag36 = x[35] ? 36'(-x) : 36'(x);
    endfunction

    function automatic ent_t sat_ent(input logic signed [36:0] x);
        if (x > ENT_LIM)
            sat_ent = ENT_LIM[34:0];
        else if (x < -ENT_LIM)
            sat_ent = 35'(-ENT_LIM);
        else
            sat_ent = x[34:0];
    endfunction

    function automatic q30_t sat_i32(input logic signed [36:0] x);
        if (x > I32_MAX)
            sat_i32 = I32_MAX[31:0];
        else if (x < I32_MIN)
            sat_i32 = I32_MIN[31:0];
        else
            sat_i32 = x[31:0];
    endfunction

endpackage
`default_nettype wire

// ----- design/jacobi_eigen_3x3_symmetric_unit.sv -----
// Top level: classical Jacobi eigen solver for a symmetric 3x3 matrix, Q16.16 in.
//
// channel  dir  handshake           payload
// s_*      in   s_tvalid/s_tready   s_tdata: m00 m01 m02 m11 m12 m22 (32 b each)
// m_*      out  m_tvalid/m_tready   m_tdata: value vec_x vec_y vec_z, m_tuser, m_tlast
// cfg_*    in   cfg_we              cfg_addr, cfg_wdata
//
// One matrix at a time: ready only in idle. A rotation is made of two 32-step
// square roots, two 31-step divides and 18 multiplies on one shared multiplier;
// up to max_rotations rotations, then three output beats. Reset is asynchronous;
// it clears control state and the configuration registers, not the datapath.
// A stalled output beat holds the results and the state machine until taken.
`default_nettype none
module jacobi_eigen_3x3_symmetric_unit (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [191:0] s_tdata,   // m00, m01, m02, m11, m12, m22
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [127:0]      m_tdata,   // eigen_value, vec_x, vec_y, vec_z
    output logic [1:0]        m_tuser,   // pair_index
    output logic              m_tlast,
    input  wire logic         cfg_we,
    input  wire logic [0:0]   cfg_addr,
    input  wire logic [30:0]  cfg_wdata
);

    jes_pkg::state_t state_reg, state_next;

    jes_pkg::ent_t dm_reg [6];
    jes_pkg::q30_t rm_reg [9];

    logic [4:0]  max_rot_reg;
    logic [30:0] thr_reg;
    logic [4:0]  iter_reg;
    logic [1:0]  pv_reg;
    logic        sec_reg;
    logic [4:0]  cnt_reg;
    logic [4:0]  op_reg;
    logic        sub_reg;
    logic [1:0]  oi_reg;

    logic        neg_reg;
    logic [34:0] ua_reg, ub_reg;
    logic [64:0] sum_reg;
    logic [63:0] rad_reg;
    logic [34:0] rrem_reg;
    logic [31:0] root_reg;
    logic [32:0] drem_reg;
    logic [30:0] dnum_reg;
    logic [32:0] den_reg;
    logic [30:0] quot_reg;
    logic [30:0] tq_reg;
    jes_pkg::q30_t t_reg, c_reg, s_reg;
    logic [64:0] prod_reg;
    logic        pneg_reg;
    logic signed [35:0] acc_reg;
    logic signed [36:0] np_reg;

    logic s_acc, m_acc;
    assign s_acc = s_tvalid && s_tready;
    assign m_acc = m_tvalid && m_tready;

    // pivot index decode
    logic [2:0] pp, qq, pq, kp, kq;
    logic [1:0] pc, qc;
    always_comb
    begin
        unique case (pv_reg)
            jes_pkg::PV_01:
            begin
                pp = 3'd0; qq = 3'd3; pq = 3'd1; kp = 3'd2; kq = 3'd4; pc = 2'd0; qc = 2'd1;
            end
            jes_pkg::PV_02:
            begin
                pp = 3'd0; qq = 3'd5; pq = 3'd2; kp = 3'd1; kq = 3'd4; pc = 2'd0; qc = 2'd2;
            end
            default:
            begin
                pp = 3'd3; qq = 3'd5; pq = 3'd4; kp = 3'd1; kq = 3'd2; pc = 2'd1; qc = 2'd2;
            end
        endcase
    end

    // pivot search
    logic [35:0] mg01, mg02, mg12, best;
    logic [1:0]  pv_sel;
    logic        stop_rot;
    always_comb
    begin
        mg01 = jes_pkg::mag36(36'(dm_reg[1]));
        mg02 = jes_pkg::mag36(36'(dm_reg[2]));
        mg12 = jes_pkg::mag36(36'(dm_reg[4]));
        best = mg01;
        pv_sel = jes_pkg::PV_01;
        if (mg02 > best)
        begin
            best = mg02;
            pv_sel = jes_pkg::PV_02;
        end
        if (mg12 > best)
        begin
            best = mg12;
            pv_sel = jes_pkg::PV_12;
        end
        stop_rot = (iter_reg >= max_rot_reg) || (best < 36'(thr_reg));
    end

    // rotation setup
    logic signed [35:0] a_val, b_val;
    logic [35:0] ua_mag, ub_mag;
    logic        pivot_zero;
    always_comb
    begin
        a_val = 36'(dm_reg[pp]) - 36'(dm_reg[qq]);
        b_val = {dm_reg[pq], 1'b0};
        ua_mag = jes_pkg::mag36(a_val);
        ub_mag = jes_pkg::mag36(b_val);
        pivot_zero = (dm_reg[pq] == '0);
    end

    logic [34:0] norm_m;
    logic        norm_hi, norm_lo;
    always_comb
    begin
        norm_m = (ua_reg > ub_reg) ? ua_reg : ub_reg;
        norm_hi = (norm_m[34:31] != 4'd0);
        norm_lo = !norm_m[30];
    end

    // multiply operand select
    logic [4:0] opm;
    logic [1:0] grp, jop, row;
    logic [3:0] ip, iq;
    logic signed [35:0] xv, kpv, kqv;
    jes_pkg::q30_t yv;
    logic [35:0] xmag, ymag;
    logic [33:0] mul_a;
    logic [30:0] mul_b;
    logic        mul_neg;
    always_comb
    begin
        opm = op_reg - 5'd2;
        grp = opm[3:2];
        jop = opm[1:0];
        row = grp - 2'd1;
        ip = 4'({2'b0, row} * 4'd3) + 4'(pc);
        iq = 4'({2'b0, row} * 4'd3) + 4'(qc);
        if (grp == 2'd0)
        begin
            kpv = 36'(dm_reg[kp]);
            kqv = 36'(dm_reg[kq]);
        end
        else
        begin
            kpv = 36'(rm_reg[ip]);
            kqv = 36'(rm_reg[iq]);
        end
        if (op_reg == jes_pkg::OP_S)
        begin
            xv = 36'(t_reg);
            yv = c_reg;
        end
        else if (op_reg == jes_pkg::OP_DIAG)
        begin
            xv = 36'(dm_reg[pq]);
            yv = t_reg;
        end
        else
        begin
            case (jop)
                jes_pkg::J_KPC: begin xv = kpv; yv = c_reg; end
                jes_pkg::J_KQS: begin xv = kqv; yv = s_reg; end
                jes_pkg::J_KQC: begin xv = kqv; yv = c_reg; end
                default:        begin xv = kpv; yv = s_reg; end
            endcase
        end
        xmag = jes_pkg::mag36(xv);
        ymag = jes_pkg::mag36(36'(yv));
        mul_a = '0;
        mul_b = '0;
        mul_neg = 1'b0;
        case (state_reg)
            jes_pkg::S_SQA:
            begin
                mul_a = 34'(ua_reg[30:0]);
                mul_b = ua_reg[30:0];
            end
            jes_pkg::S_SQB:
            begin
                mul_a = 34'(ub_reg[30:0]);
                mul_b = ub_reg[30:0];
            end
            jes_pkg::S_TSQ:
            begin
                mul_a = 34'(tq_reg);
                mul_b = tq_reg;
            end
            jes_pkg::S_MUL:
            begin
                mul_a = xmag[33:0];
                mul_b = ymag[30:0];
                mul_neg = xv[35] ^ yv[31];
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    // rounded Q2.30 product
    logic [64:0] rnd;
    logic signed [35:0] res;
    always_comb
    begin
        rnd = prod_reg + jes_pkg::HALF_Q30;
        res = $signed({1'b0, rnd[64:30]});
        if (pneg_reg)
            res = -res;
    end

    // square root step
    logic [34:0] remx, trial, rem_nx;
    logic [31:0] root_nx;
    logic        rge;
    always_comb
    begin
        remx = {rrem_reg[32:0], rad_reg[63:62]};
        trial = {1'b0, root_reg, 2'b01};
        rge = (remx >= trial);
        rem_nx = rge ? (remx - trial) : remx;
        root_nx = {root_reg[30:0], rge};
    end

    // divide step and start values
    logic [33:0] rem2;
    logic        dge;
    logic [30:0] quot_nx;
    logic [61:0] dnum_init;
    logic [32:0] den_init;
    always_comb
    begin
        rem2 = {drem_reg, dnum_reg[30]};
        dge = (rem2 >= {1'b0, den_reg});
        quot_nx = {quot_reg[29:0], dge};
        if (!sec_reg)
        begin
            dnum_init = {1'b0, ub_reg[30:0], 30'd0};
            den_init = 33'(ua_reg[30:0]) + 33'(root_nx);
        end
        else
        begin
            dnum_init = jes_pkg::ONE_60[61:0] + 62'(root_nx[31:1]);
            den_init = 33'(root_nx);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            jes_pkg::S_IDLE:  if (s_acc) state_next = jes_pkg::S_PIVOT;
            jes_pkg::S_PIVOT: state_next = stop_rot ? jes_pkg::S_OUT : jes_pkg::S_PREP;
            jes_pkg::S_PREP:  state_next = pivot_zero ? jes_pkg::S_PIVOT : jes_pkg::S_NORM;
            jes_pkg::S_NORM:  if (!norm_hi && !norm_lo) state_next = jes_pkg::S_SQA;
            jes_pkg::S_SQA:   state_next = jes_pkg::S_SQB;
            jes_pkg::S_SQB:   state_next = jes_pkg::S_SQC;
            jes_pkg::S_SQC:   state_next = jes_pkg::S_ROOT;
            jes_pkg::S_ROOT:  if (cnt_reg == 5'd0) state_next = jes_pkg::S_DIV;
            jes_pkg::S_DIV:
                if (cnt_reg == 5'd0)
                    state_next = sec_reg ? jes_pkg::S_MUL : jes_pkg::S_TSQ;
            jes_pkg::S_TSQ:   state_next = jes_pkg::S_TSQB;
            jes_pkg::S_TSQB:  state_next = jes_pkg::S_ROOT;
            jes_pkg::S_MUL:
                if (sub_reg && op_reg == jes_pkg::OP_LAST) state_next = jes_pkg::S_PIVOT;
            jes_pkg::S_OUT:
                if (m_acc && oi_reg == jes_pkg::PAIR_LAST) state_next = jes_pkg::S_IDLE;
            default:          state_next = jes_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= jes_pkg::S_IDLE;
            max_rot_reg <= jes_pkg::MAX_ROT_RESET;
            thr_reg <= jes_pkg::THRESH_RESET;
            iter_reg <= '0;
            pv_reg <= jes_pkg::PV_01;
            sec_reg <= 1'b0;
            cnt_reg <= '0;
            op_reg <= '0;
            sub_reg <= 1'b0;
            oi_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_addr)
                    jes_pkg::CFG_MAX_ROT: max_rot_reg <= cfg_wdata[4:0];
                    default:              thr_reg <= cfg_wdata;
                endcase
            end
            case (state_reg)
                jes_pkg::S_IDLE:
                    iter_reg <= '0;
                jes_pkg::S_PIVOT:
                begin
                    pv_reg <= pv_sel;
                    oi_reg <= '0;
                end
                jes_pkg::S_PREP:
                begin
                    sec_reg <= 1'b0;
                    if (pivot_zero)
                        iter_reg <= iter_reg + 5'd1;
                end
                jes_pkg::S_SQC:
                    cnt_reg <= jes_pkg::ROOT_STEPS;
                jes_pkg::S_TSQB:
                    cnt_reg <= jes_pkg::ROOT_STEPS;
                jes_pkg::S_ROOT:
                    cnt_reg <= (cnt_reg == 5'd0) ? jes_pkg::DIV_STEPS : cnt_reg - 5'd1;
                jes_pkg::S_DIV:
                begin
                    cnt_reg <= cnt_reg - 5'd1;
                    if (cnt_reg == 5'd0)
                    begin
                        sec_reg <= 1'b1;
                        op_reg <= '0;
                        sub_reg <= 1'b0;
                    end
                end
                jes_pkg::S_MUL:
                begin
                    sub_reg <= !sub_reg;
                    if (sub_reg)
                    begin
                        op_reg <= op_reg + 5'd1;
                        if (op_reg == jes_pkg::OP_LAST)
                            iter_reg <= iter_reg + 5'd1;
                    end
                end
                jes_pkg::S_OUT:
                    if (m_acc)
                        oi_reg <= oi_reg + 2'd1;
                default:
                    cnt_reg <= cnt_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        pneg_reg <= mul_neg;
        case (state_reg)
            jes_pkg::S_IDLE:
                if (s_acc)
                begin
                    for (int i = 0; i < 6; i++)
                        dm_reg[i] <= 35'($signed(s_tdata[32*i +: 32]));
                    for (int i = 0; i < 9; i++)
                        rm_reg[i] <= (i % 4 == 0) ? jes_pkg::Q30_ONE : '0;
                end
            jes_pkg::S_PREP:
            begin
                neg_reg <= (a_val != '0) && (a_val[35] != b_val[35]);
                ua_reg <= ua_mag[34:0];
                ub_reg <= ub_mag[34:0];
            end
            jes_pkg::S_NORM:
                if (norm_hi)
                begin
                    ua_reg <= ua_reg >> 1;
                    ub_reg <= ub_reg >> 1;
                end
                else if (norm_lo)
                begin
                    ua_reg <= ua_reg << 1;
                    ub_reg <= ub_reg << 1;
                end
            jes_pkg::S_SQB:
                sum_reg <= prod_reg;
            jes_pkg::S_SQC:
            begin
                rad_reg <= sum_reg[63:0] + prod_reg[63:0];
                rrem_reg <= '0;
                root_reg <= '0;
            end
            jes_pkg::S_TSQB:
            begin
                rad_reg <= prod_reg[63:0] + jes_pkg::ONE_60;
                rrem_reg <= '0;
                root_reg <= '0;
            end
            jes_pkg::S_ROOT:
            begin
                rrem_reg <= rem_nx;
                root_reg <= root_nx;
                rad_reg <= rad_reg << 2;
                if (cnt_reg == 5'd0)
                begin
                    drem_reg <= 33'(dnum_init[61:31]);
                    dnum_reg <= dnum_init[30:0];
                    den_reg <= den_init;
                    quot_reg <= '0;
                end
            end
            jes_pkg::S_DIV:
            begin
                drem_reg <= dge ? 33'(rem2 - {1'b0, den_reg}) : rem2[32:0];
                dnum_reg <= dnum_reg << 1;
                quot_reg <= quot_nx;
                if (cnt_reg == 5'd0)
                begin
                    if (!sec_reg)
                    begin
                        tq_reg <= quot_nx;
                        t_reg <= neg_reg ? -32'(quot_nx) : 32'(quot_nx);
                    end
                    else
                        c_reg <= 32'(quot_nx);
                end
            end
            jes_pkg::S_MUL:
                if (sub_reg)
                begin
                    if (op_reg == jes_pkg::OP_S)
                        s_reg <= res[31:0];
                    else if (op_reg == jes_pkg::OP_DIAG)
                    begin
                        dm_reg[pp] <= jes_pkg::sat_ent(37'(dm_reg[pp]) + 37'(res));
                        dm_reg[qq] <= jes_pkg::sat_ent(37'(dm_reg[qq]) - 37'(res));
                        dm_reg[pq] <= '0;
                    end
                    else
                    begin
                        case (jop)
                            jes_pkg::J_KPC: acc_reg <= res;
                            jes_pkg::J_KQS: np_reg <= 37'(acc_reg) + 37'(res);
                            jes_pkg::J_KQC: acc_reg <= res;
                            default:
                                if (grp == 2'd0)
                                begin
                                    dm_reg[kp] <= jes_pkg::sat_ent(np_reg);
                                    dm_reg[kq] <= jes_pkg::sat_ent(37'(acc_reg) - 37'(res));
                                end
                                else
                                begin
                                    rm_reg[ip] <= jes_pkg::sat_i32(np_reg);
                                    rm_reg[iq] <= jes_pkg::sat_i32(37'(acc_reg) - 37'(res));
                                end
                        endcase
                    end
                end
            default:
                acc_reg <= acc_reg;
        endcase
    end

    logic [2:0] diag_idx;
    always_comb
    begin
        case (oi_reg)
            2'd0:    diag_idx = 3'd0;
            2'd1:    diag_idx = 3'd3;
            default: diag_idx = 3'd5;
        endcase
    end

    assign s_tready = (state_reg == jes_pkg::S_IDLE);
    assign m_tvalid = (state_reg == jes_pkg::S_OUT);
    assign m_tdata  = {rm_reg[4'd6 + 4'(oi_reg)], rm_reg[4'd3 + 4'(oi_reg)],
                       rm_reg[4'(oi_reg)], jes_pkg::sat_i32(37'(dm_reg[diag_idx]))};
    assign m_tuser  = oi_reg;
    assign m_tlast  = (oi_reg == jes_pkg::PAIR_LAST);

`ifndef NO_ASSERTIONS
    a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !m_tvalid)
        else $error("input ready while results pending");
    a_last_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (m_tuser == jes_pkg::PAIR_LAST))
        else $error("last flag on wrong pair");
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == jes_pkg::S_PIVOT))
        else $error("accepted matrix did not start pivot search");
`endif

endmodule
`default_nettype wire
